// File: sv/savage_dueling_bandit_selector_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dueling-bandit pair selector
// Shared property forms, clocked on i_clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SAVAGE_DUELING_BANDIT_SELECTOR_DEFINES_SVH
`define SAVAGE_DUELING_BANDIT_SELECTOR_DEFINES_SVH

// Check a consequence in the same cycle as its cause.
`define SDB_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause.
`define SDB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/sdb_pkg.sv
// ----------------------------------------------------------------------------
// Dueling-bandit selector package
// Field widths, fixed-point constants, register codes and the pair entry type.
// ----------------------------------------------------------------------------
package sdb_pkg;

    localparam int MAX_ARMS = 16;

    localparam int CNT_W  = 32;
    localparam int UB_W   = 20;
    localparam int LB_W   = 21;
    localparam int NUM_W  = 24;
    localparam int FRAC_W = 16;
    localparam int ARMS_W = 5;
    localparam int DIV_NW = 48;
    localparam int DIV_DW = 33;
    localparam int SQ_IW  = 40;
    localparam int SQ_OW  = 20;

    localparam logic [UB_W-1:0]        HALF_Q16   = 20'd32768;
    localparam logic [UB_W-1:0]        ONE_Q16    = 20'd65536;
    localparam logic [UB_W-1:0]        UB_MAX     = 20'hFFFFF;
    localparam logic signed [LB_W-1:0] HALF_Q16_S = 21'sd32768;
    localparam logic signed [LB_W-1:0] ONE_Q16_S  = 21'sd65536;

    localparam logic [ARMS_W-1:0] ARMS_RST = 5'd16;
    localparam logic [NUM_W-1:0]  NUM_RST  = 24'd1812758;

    typedef enum logic [1:0] {
        REG_ARMS = 2'd0,
        REG_MODE = 2'd1,
        REG_NUM  = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [CNT_W-1:0]        cnt;
        logic [CNT_W-1:0]        wins;
        logic [UB_W-1:0]         ub;
        logic signed [LB_W-1:0]  lb;
        logic                    mask;
    } t_entry;

    // Unit handshake: start pulse in, done pulse out.
    typedef struct packed {
        logic start;
    } t_unit_req;

    typedef struct packed {
        logic done;
    } t_unit_rsp;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] a, input logic b);
        logic [CNT_W-1:0] res;
        if (b && (&a)) begin
            res = a;
        end else begin
            res = a + CNT_W'(b);
        end
        return res;
    endfunction

endpackage

// File: sv/sdb_div.sv
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sdb_div import sdb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_unit_req         i_req,
    input  logic [DIV_NW-1:0] i_dividend,
    input  logic [DIV_DW-1:0] i_divisor,
    output t_unit_rsp         o_rsp,
    output logic [DIV_NW-1:0] o_quotient
);

    localparam int CW = $clog2(DIV_NW + 1);

    logic [CW-1:0]     r_cnt;
    logic [DIV_DW-1:0] r_div;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_NW-1:0] r_quo;
    logic              r_done;
    logic [DIV_DW:0]   shifted;
    logic [DIV_DW:0]   diff;
    logic              fits;

    assign shifted = {r_rem, r_quo[DIV_NW-1]};
    assign fits    = shifted >= {1'b0, r_div};
    assign diff    = shifted - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_quo <= i_dividend;
                r_div <= i_divisor;
                r_rem <= '0;
                r_cnt <= CW'(DIV_NW);
            end else if (r_cnt != '0) begin
                r_rem <= fits ? diff[DIV_DW-1:0] : shifted[DIV_DW-1:0];
                r_quo <= {r_quo[DIV_NW-2:0], fits};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_quotient = r_quo;

endmodule

// File: sv/sdb_isqrt.sv
// ----------------------------------------------------------------------------
// Iterative integer square root
// Digit recurrence, one root bit per cycle, floor result.
// ----------------------------------------------------------------------------
module sdb_isqrt import sdb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_unit_req        i_req,
    input  logic [SQ_IW-1:0] i_value,
    output t_unit_rsp        o_rsp,
    output logic [SQ_OW-1:0] o_root
);

    localparam int CW   = $clog2(SQ_OW + 1);
    localparam int REMW = SQ_OW + 2;

    logic [CW-1:0]    r_cnt;
    logic [SQ_IW-1:0] r_val;
    logic [REMW-1:0]  r_rem;
    logic [SQ_OW-1:0] r_root;
    logic             r_done;
    logic [REMW-1:0]  rem2;
    logic [REMW-1:0]  trial;
    logic             fits;

    assign rem2  = {r_rem[REMW-3:0], r_val[SQ_IW-1:SQ_IW-2]};
    assign trial = {r_root, 2'b01};
    assign fits  = rem2 >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_val  <= i_value;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= CW'(SQ_OW);
            end else if (r_cnt != '0) begin
                r_val  <= {r_val[SQ_IW-3:0], 2'b00};
                r_rem  <= fits ? (rem2 - trial) : rem2;
                r_root <= {r_root[SQ_OW-2:0], fits};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_root     = r_root;

endmodule

// File: sv/savage_dueling_bandit_selector.sv
// ----------------------------------------------------------------------------
// Dueling-bandit pair selector
// Work per request: a distinct pair runs three divides, a square root, then the tally and
//   prune scans before the result strobe. Self pair (exploring done): no divide or root.
// Throughput: one request at a time; busy falls with the one-cycle result strobe.
// Reset and every arms, mode or numerator write clear the pair table, one entry per cycle.
// ----------------------------------------------------------------------------
`include "savage_dueling_bandit_selector_defines.svh"

module savage_dueling_bandit_selector import sdb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        start,
    output logic        busy,
    input  logic        i_first_beats_second,
    // result channel
    output logic        o_valid,
    output logic [3:0]  o_first_arm,
    output logic [3:0]  o_second_arm,
    output logic [3:0]  o_winner_arm,
    output logic [3:0]  o_next_first,
    output logic [3:0]  o_next_second,
    output logic        o_exploring_done,
    output logic [3:0]  o_best_arm,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Arm index width, arm count width, pair address width.
    localparam int AW    = $clog2(MAX_ARMS);
    localparam int KW    = $clog2(MAX_ARMS + 1);
    localparam int PW    = 2 * AW;
    localparam int DEPTH = 1 << PW;
    localparam int CW    = (KW > ARMS_W) ? KW : ARMS_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD_FS, S_RD_SF, S_CALC, S_DIV_GO, S_DIV_WAIT,
        S_SQ_GO, S_SQ_WAIT, S_WR_FS, S_WR_SF, S_TALLY, S_PRUNE, S_FIN
    } t_state;

    // Which quotient the shared divider is producing.
    typedef enum logic [1:0] {
        D_ROOT, D_FS, D_SF
    } t_dsel;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state            r_state;
    t_dsel             r_dsel;
    logic [ARMS_W-1:0] r_arms;
    logic              r_mode;
    logic [NUM_W-1:0]  r_num;
    logic [PW-1:0]     r_caddr;
    logic [AW-1:0]     r_f;
    logic [AW-1:0]     r_s;
    logic              r_beat;
    t_entry            r_e_fs;
    t_entry            r_e_sf;
    logic [SQ_OW-1:0]  r_root;
    logic [UB_W-1:0]   r_ub_fs;
    logic [UB_W-1:0]   r_ub_sf;
    // scan issue side
    logic [AW-1:0]     r_i;
    logic [AW-1:0]     r_j;
    logic              r_iss;
    // scan data side, registered from issue
    logic [AW-1:0]     r_pi;
    logic [AW-1:0]     r_pj;
    logic              r_pv;
    logic [KW-1:0]     r_ut_acc;
    logic [KW-1:0]     r_lt_acc;
    logic [KW-1:0]     r_maxlow;
    logic [KW-1:0]     r_best_t;
    logic [AW-1:0]     r_best_i;
    logic [AW-1:0]     r_chosen;
    logic              r_found;
    logic [CNT_W-1:0]  r_min;
    logic [AW-1:0]     r_bi;
    logic [AW-1:0]     r_bj;

    // ------------------------------------------------------------------
    // Memories: pair table and per-arm upper tally
    // ------------------------------------------------------------------
    t_entry            pair_mem [DEPTH];
    logic [KW-1:0]     ut_mem   [MAX_ARMS];
    t_entry            r_rd;
    logic [KW-1:0]     r_ut_i;
    logic [KW-1:0]     r_ut_j;

    logic [PW-1:0]     mem_ra;
    logic              mem_we;
    logic [PW-1:0]     mem_wa;
    t_entry            mem_wd;
    logic              ut_we;

    // ------------------------------------------------------------------
    // Arm count, clamped to [2, MAX_ARMS]
    // ------------------------------------------------------------------
    logic [CW-1:0] arms_ext;
    logic [KW-1:0] k_val;
    logic [KW-1:0] k_m1;

    always_comb begin
        arms_ext = CW'(r_arms);
        if (arms_ext < CW'(2)) begin
            k_val = KW'(2);
        end else if (arms_ext > CW'(MAX_ARMS)) begin
            k_val = KW'(MAX_ARMS);
        end else begin
            k_val = KW'(arms_ext);
        end
    end

    assign k_m1 = k_val - 1'b1;

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------
    t_reg_idx cfg_idx;
    logic     cfg_we;

    assign pready  = 1'b1;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_we  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (cfg_idx)
            REG_ARMS: prdata = 32'(r_arms);
            REG_MODE: prdata = 32'(r_mode);
            REG_NUM:  prdata = 32'(r_num);
            default:  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Shared divider and square root
    // ------------------------------------------------------------------
    t_unit_req         div_req;
    t_unit_rsp         div_rsp;
    logic [DIV_NW-1:0] div_a;
    logic [DIV_DW-1:0] div_b;
    logic [DIV_NW-1:0] div_q;
    t_unit_req         sq_req;
    t_unit_rsp         sq_rsp;
    logic [SQ_OW-1:0]  sq_root;

    // Root term divides numerator*2^16 by twice the count; the ratios divide
    // wins*2^16 by the count of their own entry.
    always_comb begin
        case (r_dsel)
            D_ROOT: begin
                div_a = DIV_NW'({r_num, {FRAC_W{1'b0}}});
                div_b = {r_e_fs.cnt, 1'b0};
            end
            D_FS: begin
                div_a = {r_e_fs.wins, {FRAC_W{1'b0}}};
                div_b = DIV_DW'(r_e_fs.cnt);
            end
            default: begin
                div_a = {r_e_sf.wins, {FRAC_W{1'b0}}};
                div_b = DIV_DW'(r_e_sf.cnt);
            end
        endcase
    end

    assign div_req.start = (r_state == S_DIV_GO);
    assign sq_req.start  = (r_state == S_SQ_GO);

    sdb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_rsp      (div_rsp),
        .o_quotient (div_q)
    );

    sdb_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sq_req),
        .i_value (div_q[SQ_IW-1:0]),
        .o_rsp   (sq_rsp),
        .o_root  (sq_root)
    );

    // Upper bound = ratio + root, saturated to 20 bits.
    logic [DIV_NW:0] ub_sum;
    logic [UB_W-1:0] ub_sat;

    assign ub_sum = {1'b0, div_q} + (DIV_NW + 1)'(r_root);
    assign ub_sat = (ub_sum > (DIV_NW + 1)'(UB_MAX)) ? UB_MAX : ub_sum[UB_W-1:0];

    // ------------------------------------------------------------------
    // Pair update: counts and wins, both directions
    // ------------------------------------------------------------------
    logic   self_pair;
    t_entry n_e_fs;
    t_entry n_e_sf;

    assign self_pair = (r_f == r_s);

    always_comb begin
        n_e_fs = r_e_fs;
        n_e_sf = r_rd;
        if (self_pair) begin
            // Both halves hit the same entry: count twice, one win total.
            n_e_fs.cnt  = sat_inc(sat_inc(r_e_fs.cnt, 1'b1), 1'b1);
            n_e_fs.wins = sat_inc(r_e_fs.wins, 1'b1);
            n_e_sf      = n_e_fs;
        end else begin
            n_e_fs.cnt  = sat_inc(r_e_fs.cnt, 1'b1);
            n_e_fs.wins = sat_inc(r_e_fs.wins, r_beat);
            n_e_sf.cnt  = sat_inc(r_rd.cnt, 1'b1);
            n_e_sf.wins = sat_inc(r_rd.wins, !r_beat);
        end
    end

    // ------------------------------------------------------------------
    // Tally scan: count bounds above one half along each row
    // ------------------------------------------------------------------
    logic          off_diag;
    logic [KW-1:0] n_ut;
    logic [KW-1:0] n_lt;
    logic          row_end;

    assign off_diag = (r_pi != r_pj);
    assign n_ut     = r_ut_acc + KW'(off_diag && (r_rd.ub > HALF_Q16));
    assign n_lt     = r_lt_acc + KW'(off_diag && (r_rd.lb > HALF_Q16_S));
    assign row_end  = (KW'(r_pj) == k_m1);
    assign ut_we    = (r_state == S_TALLY) && r_pv && row_end;

    // ------------------------------------------------------------------
    // Prune scan: drop explore pairs, track least-compared survivor
    // ------------------------------------------------------------------
    logic drop;
    logic remain;
    logic better;
    logic prune_last;

    always_comb begin
        if (!r_mode) begin
            drop = (r_ut_i < k_m1) || (r_ut_j < k_m1);
        end else begin
            drop = (r_rd.lb > HALF_Q16_S) || (r_rd.ub < HALF_Q16) ||
                   ((r_maxlow > r_ut_i) && (r_maxlow > r_ut_j));
        end
    end

    assign remain     = r_rd.mask && !drop;
    assign better     = remain && (!r_found || (r_rd.cnt < r_min));
    assign prune_last = (KW'(r_pi) == k_m1) && (r_pj == r_pi - AW'(1));

    // ------------------------------------------------------------------
    // Table port steering
    // ------------------------------------------------------------------
    logic [AW-1:0] c_i;
    logic [AW-1:0] c_j;

    assign c_i = r_caddr[PW-1:AW];
    assign c_j = r_caddr[AW-1:0];

    always_comb begin
        unique case (r_state)
            S_RD_FS: mem_ra = {r_f, r_s};
            S_RD_SF: mem_ra = {r_s, r_f};
            default: mem_ra = {r_i, r_j};
        endcase
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = {r_pi, r_pj};
        mem_wd = r_rd;
        unique case (r_state)
            S_CLEAR: begin
                // Fresh entry; explore only below the diagonal of the used arms.
                mem_we      = 1'b1;
                mem_wa      = r_caddr;
                mem_wd.cnt  = '0;
                mem_wd.wins = '0;
                mem_wd.ub   = ONE_Q16;
                mem_wd.lb   = '0;
                mem_wd.mask = (KW'(c_i) < k_val) && (c_j < c_i);
            end
            S_WR_FS: begin
                mem_we    = 1'b1;
                mem_wa    = {r_f, r_s};
                mem_wd    = r_e_fs;
                mem_wd.ub = r_ub_fs;
                mem_wd.lb = ONE_Q16_S - $signed({1'b0, r_ub_sf});
            end
            S_WR_SF: begin
                mem_we    = 1'b1;
                mem_wa    = {r_s, r_f};
                mem_wd    = r_e_sf;
                mem_wd.ub = r_ub_sf;
                mem_wd.lb = ONE_Q16_S - $signed({1'b0, r_ub_fs});
            end
            S_PRUNE: begin
                mem_we      = r_pv && r_rd.mask && drop;
                mem_wd.mask = 1'b0;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // The prune write lands on the entry whose data is held in r_rd while the
    // next, different entry is read, so no forwarding is needed.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            pair_mem[mem_wa] <= mem_wd;
        end
        r_rd <= pair_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (ut_we) begin
            ut_mem[r_pi] <= n_ut;
        end
        r_ut_i <= ut_mem[r_i];
        r_ut_j <= ut_mem[r_j];
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_caddr  <= '0;
            r_arms   <= ARMS_RST;
            r_mode   <= 1'b0;
            r_num    <= NUM_RST;
            r_iss    <= 1'b0;
            r_pv     <= 1'b0;
            r_dsel   <= D_ROOT;
            o_valid  <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_caddr <= r_caddr + 1'b1;
                    if (r_caddr == {PW{1'b1}}) begin
                        // First proposal of a fresh table: arms one and zero.
                        r_f      <= AW'(1);
                        r_s      <= '0;
                        r_chosen <= '0;
                        r_state  <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_beat  <= i_first_beats_second;
                        r_state <= S_RD_FS;
                    end
                end
                S_RD_FS: begin
                    r_state <= S_RD_SF;
                end
                S_RD_SF: begin
                    r_e_fs  <= r_rd;
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    r_e_fs <= n_e_fs;
                    r_e_sf <= n_e_sf;
                    if (self_pair) begin
                        r_ub_fs <= HALF_Q16;
                        r_ub_sf <= HALF_Q16;
                        r_state <= S_WR_FS;
                    end else begin
                        r_dsel  <= D_ROOT;
                        r_state <= S_DIV_GO;
                    end
                end
                S_DIV_GO: begin
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (div_rsp.done) begin
                        case (r_dsel)
                            D_ROOT: begin
                                r_state <= S_SQ_GO;
                            end
                            D_FS: begin
                                r_ub_fs <= ub_sat;
                                r_dsel  <= D_SF;
                                r_state <= S_DIV_GO;
                            end
                            default: begin
                                r_ub_sf <= ub_sat;
                                r_state <= S_WR_FS;
                            end
                        endcase
                    end
                end
                S_SQ_GO: begin
                    r_state <= S_SQ_WAIT;
                end
                S_SQ_WAIT: begin
                    if (sq_rsp.done) begin
                        r_root  <= sq_root;
                        r_dsel  <= D_FS;
                        r_state <= S_DIV_GO;
                    end
                end
                S_WR_FS: begin
                    r_state <= S_WR_SF;
                end
                S_WR_SF: begin
                    // Arm the tally scan over every row and column in use.
                    r_i      <= '0;
                    r_j      <= '0;
                    r_iss    <= 1'b1;
                    r_pv     <= 1'b0;
                    r_ut_acc <= '0;
                    r_lt_acc <= '0;
                    r_maxlow <= '0;
                    r_best_t <= '0;
                    r_best_i <= '0;
                    r_state  <= S_TALLY;
                end
                S_TALLY: begin
                    r_pv <= r_iss;
                    r_pi <= r_i;
                    r_pj <= r_j;
                    if (r_iss) begin
                        if (KW'(r_j) == k_m1) begin
                            r_j <= '0;
                            if (KW'(r_i) == k_m1) begin
                                r_iss <= 1'b0;
                            end else begin
                                r_i <= r_i + 1'b1;
                            end
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                    end
                    if (r_pv) begin
                        if (row_end) begin
                            r_ut_acc <= '0;
                            r_lt_acc <= '0;
                            if (n_lt > r_maxlow) begin
                                r_maxlow <= n_lt;
                            end
                            // Highest upper tally, first arm on a tie.
                            if ((r_pi == '0) || (n_ut > r_best_t)) begin
                                r_best_t <= n_ut;
                                r_best_i <= r_pi;
                            end
                            if (KW'(r_pi) == k_m1) begin
                                r_i     <= AW'(1);
                                r_j     <= '0;
                                r_iss   <= 1'b1;
                                r_pv    <= 1'b0;
                                r_found <= 1'b0;
                                r_state <= S_PRUNE;
                            end
                        end else begin
                            r_ut_acc <= n_ut;
                            r_lt_acc <= n_lt;
                        end
                    end
                end
                S_PRUNE: begin
                    r_pv <= r_iss;
                    r_pi <= r_i;
                    r_pj <= r_j;
                    if (r_iss) begin
                        if (r_j == r_i - AW'(1)) begin
                            r_j <= '0;
                            if (KW'(r_i) == k_m1) begin
                                r_iss <= 1'b0;
                            end else begin
                                r_i <= r_i + 1'b1;
                            end
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                    end
                    if (r_pv) begin
                        if (better) begin
                            r_found <= 1'b1;
                            r_min   <= r_rd.cnt;
                            r_bi    <= r_pi;
                            r_bj    <= r_pj;
                        end
                        if (prune_last) begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    o_valid      <= 1'b1;
                    o_first_arm  <= 4'(r_f);
                    o_second_arm <= 4'(r_s);
                    o_winner_arm <= r_beat ? 4'(r_f) : 4'(r_s);
                    if (r_found) begin
                        r_f              <= r_bi;
                        r_s              <= r_bj;
                        o_next_first     <= 4'(r_bi);
                        o_next_second    <= 4'(r_bj);
                        o_exploring_done <= 1'b0;
                        o_best_arm       <= 4'(r_chosen);
                    end else begin
                        // Exploring over: play the best arm against itself.
                        r_chosen         <= r_best_i;
                        r_f              <= r_best_i;
                        r_s              <= r_best_i;
                        o_next_first     <= 4'(r_best_i);
                        o_next_second    <= 4'(r_best_i);
                        o_exploring_done <= 1'b1;
                        o_best_arm       <= 4'(r_best_i);
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_CLEAR;
                    r_caddr <= '0;
                end
            endcase

            // Any write to the arms, mode or numerator register restarts the whole table.
            if (cfg_we) begin
                unique case (cfg_idx)
                    REG_ARMS: begin
                        r_arms  <= pwdata[ARMS_W-1:0];
                        r_state <= S_CLEAR;
                        r_caddr <= '0;
                        r_iss   <= 1'b0;
                        r_pv    <= 1'b0;
                    end
                    REG_MODE: begin
                        r_mode  <= pwdata[0];
                        r_state <= S_CLEAR;
                        r_caddr <= '0;
                        r_iss   <= 1'b0;
                        r_pv    <= 1'b0;
                    end
                    REG_NUM: begin
                        r_num   <= pwdata[NUM_W-1:0];
                        r_state <= S_CLEAR;
                        r_caddr <= '0;
                        r_iss   <= 1'b0;
                        r_pv    <= 1'b0;
                    end
                    default: begin
                        r_arms <= r_arms;
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `SDB_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
    `SDB_ASSERT_NEXT(a_valid_pulse, o_valid, !o_valid, "result strobe longer than one cycle")
    `SDB_ASSERT_SAME(a_explore_order, o_valid && !o_exploring_done, r_f > r_s, "pair above diagonal")
    `SDB_ASSERT_SAME(a_done_self, o_valid && o_exploring_done, r_f == r_chosen && r_s == r_chosen, "bad self pair")

endmodule
